[hdl/nmea_coordinate_to_degrees_unit_macros.svh]
// ----------------------------------------------------------------------------
// NMEA coordinate converter assertion macros
// Shared property forms for the converter's internal checks.
// ----------------------------------------------------------------------------
`ifndef NMEA_COORDINATE_TO_DEGREES_UNIT_MACROS_SVH
`define NMEA_COORDINATE_TO_DEGREES_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NCTD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NCTD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/nctd_pkg.sv]
// ----------------------------------------------------------------------------
// NMEA coordinate converter package
// Payload types, job record, widths, codes and small helper functions.
// ----------------------------------------------------------------------------
package nctd_pkg;

  localparam int CHAR_W    = 8;
  localparam int MICRO_W   = 28;
  localparam int STATUS_W  = 2;
  localparam int FRAC_W    = 24;  // holds 10^7
  localparam int FCOUNT_W  = 3;
  localparam int DEG_W     = 14;  // up to four degree digits
  localparam int MINUTE_W  = 7;
  localparam int CHARS_W   = 4;
  localparam int N_W       = 30;  // scaled minutes, below 10^9

  localparam logic [CHARS_W-1:0] CHARS_SAT = '1;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_NINE = 8'h39;
  localparam logic [CHAR_W-1:0] ASCII_DOT  = 8'h2E;

  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MALFORMED  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVER_LIMIT = 2'd2;

  localparam int LAT_LIMIT   = 90;
  localparam int LON_LIMIT   = 180;
  localparam int MIN_PER_DEG = 60;
  localparam int MICRO       = 1000000;

  typedef struct packed {
    logic [CHAR_W-1:0] char_in;
    logic              is_longitude;
    logic              last_char;
  } item_t;

  typedef struct packed {
    logic [MICRO_W-1:0]  micro_degrees;
    logic [STATUS_W-1:0] status;
  } result_t;

  typedef struct packed {
    logic                malformed;
    logic                is_longitude;
    logic [DEG_W-1:0]    degrees;
    logic [MINUTE_W-1:0] minutes;
    logic [FRAC_W-1:0]   fraction;
    logic [FCOUNT_W-1:0] fraction_count;
  } job_t;

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= ASCII_ZERO) && (c <= ASCII_NINE);
  endfunction

  function automatic logic [3:0] digit_value(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] d;
    d = c - ASCII_ZERO;
    return d[3:0];
  endfunction

  function automatic logic [FRAC_W-1:0] pow10(input logic [FCOUNT_W-1:0] n);
    logic [FRAC_W-1:0] p;
    case (n)
      3'd0: p = 24'd1;
      3'd1: p = 24'd10;
      3'd2: p = 24'd100;
      3'd3: p = 24'd1000;
      3'd4: p = 24'd10000;
      3'd5: p = 24'd100000;
      3'd6: p = 24'd1000000;
      3'd7: p = 24'd10000000;
      default: p = 24'd1;
    endcase
    return p;
  endfunction

endpackage

[hdl/nmea_coordinate_to_degrees_unit.sv]
// ----------------------------------------------------------------------------
// NMEA coordinate to decimal degrees converter
// Takes a dddmm.mmmm coordinate field one ASCII character per transfer and
// returns, for each field, decimal degrees in microdegrees (truncated) with a
// status: ok, malformed, or above the 90/180 degree limit. One character is
// taken every cycle unless the job queue is full, also while results wait to
// be popped; a field's result passes from the parser through the job queue
// and the three-stage arithmetic pipeline. Input stalls (full)
// only when the two-entry job queue between parser and pipeline is full,
// which happens when the five-entry result queue is not being drained.
// ----------------------------------------------------------------------------
module nmea_coordinate_to_degrees_unit #(
  parameter int FRAC_DIGITS   = 6,
  parameter int MAX_DEG_CHARS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  nctd_pkg::item_t   item,
  output logic              empty,
  input  logic              pop,
  output nctd_pkg::result_t result
);
  import nctd_pkg::*;

  logic  accept;
  logic  front_valid;
  job_t  front_job;
  job_t  queued_job;
  logic  job_empty;
  logic  job_take;

  assign accept = push && !full;

  nctd_front #(
    .FRAC_DIGITS   (FRAC_DIGITS),
    .MAX_DEG_CHARS (MAX_DEG_CHARS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .job_valid (front_valid),
    .job       (front_job)
  );

  nctd_fifo #(
    .entry_t (job_t),
    .DEPTH   (2)
  ) u_job_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (front_valid),
    .wr_data (front_job),
    .pop     (job_take),
    .rd_data (queued_job),
    .full    (full),
    .empty   (job_empty),
    .count   ()
  );

  nctd_back #(
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (!job_empty),
    .job       (queued_job),
    .job_take  (job_take),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

[hdl/nctd_fifo.sv]
// ----------------------------------------------------------------------------
// NMEA coordinate converter queue
// Small show-ahead register queue with occupancy count.
// ----------------------------------------------------------------------------
`include "nmea_coordinate_to_degrees_unit_macros.svh"

module nctd_fifo #(
  parameter type entry_t = logic,
  parameter int  DEPTH   = 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  entry_t                       wr_data,
  input  logic                         pop,
  output entry_t                       rd_data,
  output logic                         full,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH+1);

  entry_t            mem [DEPTH];
  logic [IDX_W-1:0]  wr_ptr;
  logic [IDX_W-1:0]  rd_ptr;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == IDX_W'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == IDX_W'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  `NCTD_ASSERT_SAME(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(DEPTH), "queue count overflow")
  `NCTD_ASSERT_NEXT(a_push_fills, clk, rst, do_push && !do_pop, !empty, "transfer in lost")

endmodule

[hdl/nctd_front.sv]
// ----------------------------------------------------------------------------
// NMEA coordinate converter front end
// Parses characters into degree, minute and fraction parts and classifies
// the field; emits one job per field on its final character.
// ----------------------------------------------------------------------------
`include "nmea_coordinate_to_degrees_unit_macros.svh"

module nctd_front #(
  parameter int FRAC_DIGITS   = 6,
  parameter int MAX_DEG_CHARS = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  nctd_pkg::item_t item,
  output logic            job_valid,
  output nctd_pkg::job_t  job
);
  import nctd_pkg::*;

  localparam logic [CHARS_W-1:0]  DEG_LIMIT  = CHARS_W'(MAX_DEG_CHARS);
  localparam logic [FCOUNT_W-1:0] FRAC_LIMIT = FCOUNT_W'(FRAC_DIGITS);
  localparam logic [CHARS_W-1:0]  MIN_FIELD  = CHARS_W'(2);
  localparam logic [CHARS_W-1:0]  SHORTEST   = CHARS_W'(3);

  logic [DEG_W-1:0]    degrees, degrees_next;
  logic [CHARS_W-1:0]  chars, chars_next;
  logic                dot_seen, dot_seen_next;
  logic [FRAC_W-1:0]   fraction, fraction_next;
  logic [FCOUNT_W-1:0] fraction_count, fraction_count_next;
  logic                part_stopped, part_stopped_next;
  logic [CHAR_W-1:0]   win_old, win_old_next;
  logic [CHAR_W-1:0]   win_new, win_new_next;

  always_comb begin
    degrees_next        = degrees;
    chars_next          = chars;
    dot_seen_next       = dot_seen;
    fraction_next       = fraction;
    fraction_count_next = fraction_count;
    part_stopped_next   = part_stopped;
    win_old_next        = win_old;
    win_new_next        = win_new;
    if (!dot_seen) begin
      if (item.char_in == ASCII_DOT) begin
        dot_seen_next     = 1'b1;
        part_stopped_next = 1'b0;
      end else begin
        // character leaving the minute window belongs to the degrees
        if ((chars >= MIN_FIELD) && !part_stopped && ((chars - MIN_FIELD) < DEG_LIMIT)) begin
          if (is_digit(win_old)) begin
            degrees_next = DEG_W'(degrees * DEG_W'(10) + DEG_W'(digit_value(win_old)));
          end else begin
            part_stopped_next = 1'b1;
          end
        end
        win_old_next = win_new;
        win_new_next = item.char_in;
        if (chars != CHARS_SAT) begin
          chars_next = chars + 1'b1;
        end
      end
    end else if (!part_stopped) begin
      if (is_digit(item.char_in)) begin
        if (fraction_count < FRAC_LIMIT) begin
          fraction_next = FRAC_W'(fraction * FRAC_W'(10) + FRAC_W'(digit_value(item.char_in)));
          fraction_count_next = fraction_count + 1'b1;
        end
      end else begin
        part_stopped_next = 1'b1;
      end
    end
  end

  always_comb begin
    job              = '0;
    job.is_longitude = item.is_longitude;
    job.degrees      = degrees_next;
    job.malformed    = !dot_seen_next || (chars_next < SHORTEST) ||
                       ((chars_next - MIN_FIELD) > DEG_LIMIT);
    if (is_digit(win_old_next)) begin
      job.minutes = MINUTE_W'(digit_value(win_old_next));
      if (is_digit(win_new_next)) begin
        job.minutes = MINUTE_W'(MINUTE_W'(digit_value(win_old_next)) * MINUTE_W'(10) +
                                MINUTE_W'(digit_value(win_new_next)));
        job.fraction       = fraction_next;
        job.fraction_count = fraction_count_next;
      end
    end
  end

  assign job_valid = accept && item.last_char;

  always_ff @(posedge clk) begin
    if (rst || (accept && item.last_char)) begin
      degrees        <= '0;
      chars          <= '0;
      dot_seen       <= 1'b0;
      fraction       <= '0;
      fraction_count <= '0;
      part_stopped   <= 1'b0;
      win_old        <= '0;
      win_new        <= '0;
    end else if (accept) begin
      degrees        <= degrees_next;
      chars          <= chars_next;
      dot_seen       <= dot_seen_next;
      fraction       <= fraction_next;
      fraction_count <= fraction_count_next;
      part_stopped   <= part_stopped_next;
      win_old        <= win_old_next;
      win_new        <= win_new_next;
    end
  end

  `NCTD_ASSERT_NEXT(a_field_cleared, clk, rst, accept && item.last_char, (chars == '0) && !dot_seen && !part_stopped && (fraction_count == '0), "parser state not cleared after field")
  `NCTD_ASSERT_SAME(a_fraction_bound, clk, rst, 1'b1, fraction_count <= FRAC_LIMIT, "fraction digit count beyond limit")

endmodule

[hdl/nctd_back.sv]
// ----------------------------------------------------------------------------
// NMEA coordinate converter back end
// Three-stage pipeline: scale minutes, multiply, then limit check and sum.
// Issues only with a free slot reserved in the result queue.
// ----------------------------------------------------------------------------
`include "nmea_coordinate_to_degrees_unit_macros.svh"

module nctd_back #(
  parameter int FRAC_DIGITS = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  input  nctd_pkg::job_t    job,
  output logic              job_take,
  output nctd_pkg::result_t result,
  output logic              empty,
  input  logic              pop
);
  import nctd_pkg::*;

  localparam int     OUT_DEPTH = 5;
  localparam int     OCC_W     = $clog2(OUT_DEPTH+1) + 1;
  localparam int     PW        = (FRAC_DIGITS > 6) ? FRAC_DIGITS : 6;
  localparam longint DIVISOR   = longint'(MIN_PER_DEG) * longint'(pow10(FCOUNT_W'(PW-6)));
  localparam int     SHIFT     = N_W + $clog2(DIVISOR);
  localparam longint RECIP     = ((longint'(1) << SHIFT) + DIVISOR - 1) / DIVISOR;
  localparam int     RECIP_W   = 32;
  localparam int     PROD_W    = N_W + RECIP_W;
  localparam int     Q_W       = PROD_W - SHIFT;
  localparam int     TOTAL_W   = DEG_W + N_W;
  localparam int     DMIC_W    = DEG_W + 20;
  localparam longint DEG_SCALE = longint'(MIN_PER_DEG) * longint'(pow10(FCOUNT_W'(PW)));

  localparam logic [FRAC_W-1:0]   SCALE_C     = pow10(FCOUNT_W'(PW));
  localparam logic [FCOUNT_W-1:0] PW_C        = FCOUNT_W'(PW);
  localparam logic [RECIP_W-1:0]  RECIP_C     = RECIP_W'(RECIP);
  localparam logic [N_W-1:0]      DEG_SCALE_C = N_W'(DEG_SCALE);
  localparam logic [19:0]         MICRO_C     = 20'(MICRO);
  localparam logic [TOTAL_W-1:0]  LIM_LAT_C   = TOTAL_W'(longint'(LAT_LIMIT) * DEG_SCALE);
  localparam logic [TOTAL_W-1:0]  LIM_LON_C   = TOTAL_W'(longint'(LON_LIMIT) * DEG_SCALE);

  // stage 1
  logic                 v1;
  logic [N_W-1:0]       s1_n;
  logic [DEG_W-1:0]     s1_degrees;
  logic                 s1_lon;
  logic                 s1_malformed;
  // stage 2
  logic                 v2;
  logic [PROD_W-1:0]    s2_qprod;
  logic [TOTAL_W-1:0]   s2_dscaled;
  logic [MICRO_W-1:0]   s2_dmicro;
  logic [N_W-1:0]       s2_n;
  logic                 s2_lon;
  logic                 s2_malformed;
  // stage 3
  logic                 v3;
  result_t              s3_result;

  logic [2*FRAC_W-1:0]        frac_scaled;
  logic [MINUTE_W+FRAC_W-1:0] min_scaled;
  logic [N_W-1:0]             n_calc;
  logic [DMIC_W-1:0]          dmicro_full;
  logic [TOTAL_W-1:0]         total;
  logic [TOTAL_W-1:0]         limit;
  logic [Q_W-1:0]             q;
  logic [MICRO_W-1:0]         micro_sum;
  result_t                    result_calc;
  logic [$clog2(OUT_DEPTH+1)-1:0] out_count;
  logic [OCC_W-1:0]           occupancy;

  assign occupancy = OCC_W'(out_count) + OCC_W'(v1) + OCC_W'(v2) + OCC_W'(v3);
  assign job_take  = job_valid && (occupancy < OCC_W'(OUT_DEPTH));

  always_comb begin
    frac_scaled = job.fraction * pow10(PW_C - job.fraction_count);
    min_scaled  = job.minutes * SCALE_C;
    n_calc      = N_W'(min_scaled) + N_W'(frac_scaled);
  end

  assign dmicro_full = s1_degrees * MICRO_C;

  always_comb begin
    total       = s2_dscaled + TOTAL_W'(s2_n);
    limit       = s2_lon ? LIM_LON_C : LIM_LAT_C;
    q           = s2_qprod[PROD_W-1:SHIFT];
    micro_sum   = s2_dmicro + MICRO_W'(q);
    result_calc = '0;
    if (s2_malformed) begin
      result_calc.status = STATUS_MALFORMED;
    end else if (total > limit) begin
      result_calc.status = STATUS_OVER_LIMIT;
    end else begin
      result_calc.status        = STATUS_OK;
      result_calc.micro_degrees = micro_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= job_take;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    s1_n         <= n_calc;
    s1_degrees   <= job.degrees;
    s1_lon       <= job.is_longitude;
    s1_malformed <= job.malformed;
    s2_qprod     <= s1_n * RECIP_C;
    s2_dscaled   <= s1_degrees * DEG_SCALE_C;
    s2_dmicro    <= dmicro_full[MICRO_W-1:0];
    s2_n         <= s1_n;
    s2_lon       <= s1_lon;
    s2_malformed <= s1_malformed;
    s3_result    <= result_calc;
  end

  nctd_fifo #(
    .entry_t (result_t),
    .DEPTH   (OUT_DEPTH)
  ) u_out_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (v3),
    .wr_data (s3_result),
    .pop     (pop),
    .rd_data (result),
    .full    (),
    .empty   (empty),
    .count   (out_count)
  );

  `NCTD_ASSERT_SAME(a_slot_reserved, clk, rst, 1'b1, occupancy <= OCC_W'(OUT_DEPTH), "result queue overbooked")
  `NCTD_ASSERT_SAME(a_room_on_write, clk, rst, v3, out_count < OCC_W'(OUT_DEPTH), "result written into full queue")

endmodule
